### sv/sem_pkg.sv
`timescale 1ns / 1ps

package sem_pkg;

	// Register indexes on the configuration port.
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [10:0] WIDTH_RESET  = 11'd640;
	localparam logic [11:0] HEIGHT_RESET = 12'd480;

	// Number of root cells, one result bit each, and the saturated magnitude.
	localparam int         SQRT_STEPS = 8;
	localparam logic [7:0] MAG_MAX    = 8'd255;

	// Front end sequencer states.
	typedef enum logic {
		FE_IDLE,
		FE_CALC
	} fe_state_t;

	// Partial square root carried from one cell to the next.
	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] root;
		logic        sat;
		logic        row_end;
		logic        frame_end;
	} sq_t;

endpackage

### sv/sem_line_ram.sv
`timescale 1ns / 1ps

module sem_line_ram import sem_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [15:0]              rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [15:0]              wr_data
);

	// Both line buffers side by side: older row in the upper byte.
	logic [15:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/sem_sqrt_cell.sv
`timescale 1ns / 1ps

module sem_sqrt_cell import sem_pkg::*; #(
	parameter int K = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sq_t  in_data,
	output logic in_ready,
	output logic out_valid,
	output sq_t  out_data,
	input  logic out_ready
);

	localparam logic [15:0] BIT = 16'(1) << (14 - 2 * K);

	logic [16:0] trial;
	sq_t         nxt;

	// One restoring step of the digit-by-digit root.
	always_comb begin
		trial = {1'b0, in_data.root} + {1'b0, BIT};
		nxt   = in_data;
		if ({1'b0, in_data.rem} >= trial) begin
			nxt.rem  = in_data.rem - trial[15:0];
			nxt.root = (in_data.root >> 1) + BIT;
		end else begin
			nxt.root = in_data.root >> 1;
		end
	end

	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_data <= nxt;
		end
	end

endmodule

### sv/sobel_edge_magnitude_top.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     in_valid / in_stall       gray_pixel
// output    out_valid / out_stall     edge_magnitude, row_end, frame_end
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The accept cycle issues the line-buffer read; FE_CALC then forms the gradients,
// writes the line buffer back and stalls input; it waits on a full gradient stage.
// A result passes the gradient and square registers, eight root cells and the
// output register. Reset clears counters, window and valids; the line buffers
// need no clearing. Output stall backs up through the root cells.

module sobel_edge_magnitude_top import sem_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  gray_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  edge_magnitude,
	output logic        row_end,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int COLW = $clog2(MAX_WIDTH);
	localparam int EW   = (COLW + 1 > 11) ? COLW + 1 : 11;

	logic [10:0] width_q;
	logic [11:0] height_q;
	fe_state_t   state_q, state_d;
	logic [COLW-1:0] col_q;
	logic [11:0] row_q;
	logic [7:0]  pix_q;
	logic [7:0]  win_q [6];
	logic [15:0] rd_data;
	logic        accept, fire, emit, last_col, last_row;
	logic [EW-1:0] w_ext, w_eff;
	logic [11:0] h_eff;
	logic [7:0]  a, b;
	logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;

	logic signed [10:0] gx_s2, gy_s2;
	logic        v_s2, re_s2, fe_s2, rdy_s2;
	logic [19:0] sqx_s3, sqy_s3;
	logic        v_s3, re_s3, fe_s3, rdy_s3;
	logic [21:0] px, py;
	logic [20:0] sum;

	logic        cv  [SQRT_STEPS+1];
	sq_t         cd  [SQRT_STEPS+1];
	logic        crd [SQRT_STEPS+1];
	logic        out_ready;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[10:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective frame size and position flags.
	always_comb begin
		w_ext = EW'(width_q);
		if (w_ext < EW'(3)) w_eff = EW'(3);
		else if (w_ext > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
		else w_eff = w_ext;
		h_eff    = (height_q < 12'd3) ? 12'd3 : height_q;
		last_col = (EW'(col_q) + EW'(1)) >= w_eff;
		last_row = ({1'b0, row_q} + 13'd1) >= {1'b0, h_eff};
		emit     = (col_q >= COLW'(2)) && (row_q >= 12'd2);
	end

	// Front end sequencer: accept a pixel, then compute and write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FE_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		fire    = 1'b0;
		case (state_q)
			FE_IDLE: if (in_valid) state_d = FE_CALC;
			FE_CALC: begin
				fire = !emit || rdy_s2;
				if (fire) state_d = FE_IDLE;
			end
			default: state_d = FE_IDLE;
		endcase
	end

	assign in_stall = (state_q != FE_IDLE);
	assign accept   = in_valid && !in_stall;

	sem_line_ram #(.DEPTH(MAX_WIDTH)) u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (fire),
		.wr_addr (col_q),
		.wr_data ({b, pix_q})
	);

	assign a = rd_data[15:8];
	assign b = rd_data[7:0];

	always_ff @(posedge clk) begin
		if (accept) pix_q <= gray_pixel;
	end

	// Window shift and raster counters advance once per pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (fire) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= a;
			win_q[4] <= b;
			win_q[5] <= pix_q;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + COLW'(1);
			end
		end
	end

	// Sobel sums for both directions.
	always_comb begin
		gx_pos = 10'(a) + {1'b0, b, 1'b0} + 10'(pix_q);
		gx_neg = 10'(win_q[0]) + {1'b0, win_q[1], 1'b0} + 10'(win_q[2]);
		gy_pos = 10'(win_q[2]) + {1'b0, win_q[5], 1'b0} + 10'(pix_q);
		gy_neg = 10'(win_q[0]) + {1'b0, win_q[3], 1'b0} + 10'(a);
	end

	// Gradient stage.
	assign rdy_s2 = !v_s2 || rdy_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (rdy_s2) v_s2 <= fire && emit;
	end
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			gx_s2 <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
			gy_s2 <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
			re_s2 <= last_col;
			fe_s2 <= last_col && last_row;
		end
	end

	// Squaring stage.
	assign px     = gx_s2 * gx_s2;
	assign py     = gy_s2 * gy_s2;
	assign rdy_s3 = !v_s3 || crd[0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (rdy_s3) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sqx_s3 <= px[19:0];
			sqy_s3 <= py[19:0];
			re_s3  <= re_s2;
			fe_s3  <= fe_s2;
		end
	end

	// Sum of squares enters the root chain.
	assign sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	always_comb begin
		cv[0]           = v_s3;
		cd[0].rem       = sum[15:0];
		cd[0].root      = '0;
		cd[0].sat       = (sum[20:16] != 5'd0);
		cd[0].row_end   = re_s3;
		cd[0].frame_end = fe_s3;
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
		sem_sqrt_cell #(.K(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[k]),
			.in_data   (cd[k]),
			.in_ready  (crd[k]),
			.out_valid (cv[k+1]),
			.out_data  (cd[k+1]),
			.out_ready (crd[k+1])
		);
	end

	// Output register.
	assign out_ready       = !out_valid || !out_stall;
	assign crd[SQRT_STEPS] = out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_ready) out_valid <= cv[SQRT_STEPS];
	end
	always_ff @(posedge clk) begin
		if (out_ready) begin
			edge_magnitude <= cd[SQRT_STEPS].sat ? MAG_MAX : cd[SQRT_STEPS].root[7:0];
			row_end        <= cd[SQRT_STEPS].row_end;
			frame_end      <= cd[SQRT_STEPS].frame_end;
		end
	end

endmodule

### sv/sem_checker.sv
`timescale 1ns / 1ps

module sem_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] gray_pixel,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] edge_magnitude,
	input logic       row_end,
	input logic       frame_end
);

	// A held input transaction keeps its pixel.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> $stable(gray_pixel))
		else $error("input pixel changed while stalled");

	// A stalled result stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(edge_magnitude)
			&& $stable(row_end) && $stable(frame_end))
		else $error("result dropped or changed while stalled");

	// Frame end only falls on a row end.
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !frame_end || row_end)
		else $error("frame end without row end");

	// An accepted pixel blocks the next cycle while the line buffer is written.
	a_one_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("pixel accepted in back-to-back cycles");

endmodule

bind sobel_edge_magnitude_top sem_checker u_sem_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.gray_pixel     (gray_pixel),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.edge_magnitude (edge_magnitude),
	.row_end        (row_end),
	.frame_end      (frame_end)
);
